// ===== rtl/spanning_tree_bpdu_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Spanning-tree engine assertion macros
// Shared assertion wrappers clocked on clk_i and gated by reset.
// ----------------------------------------------------------------------------
`ifndef SPANNING_TREE_BPDU_ENGINE_DEFINES_SVH
`define SPANNING_TREE_BPDU_ENGINE_DEFINES_SVH

// check a property on every clock edge out of reset
`define STP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition never holds
`define STP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// Spanning-tree engine package
// Widths, codes, the priority vector type and shared helpers.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int MAX_PORTS = 8;
  localparam int IDX_W     = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int CNT_RAW   = $clog2(MAX_PORTS + 1);
  localparam int CNT_W     = (CNT_RAW > 4) ? CNT_RAW : 4;
  localparam int OUT_LIMIT = 8;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_MSG   = 2'd1,
    OP_HELLO = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_OWN_ID   = 2'd0,
    REG_PORTS    = 2'd1,
    REG_PRIORITY = 2'd2,
    REG_COST     = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MATCH,
    ST_ANSWER,
    ST_SELECT,
    ST_ROOT,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  // field order gives lexicographic compare as one unsigned compare
  typedef struct packed {
    logic [63:0] root;
    logic [31:0] cost;
    logic [63:0] bridge;
    logic [15:0] ident;
  } vec_t;

  function automatic logic [15:0] ident_of(input logic [7:0] prio, input logic [7:0] idx);
    logic [7:0] lo;
    lo = idx + 8'd1;
    return {prio, lo};
  endfunction

endpackage

// ===== rtl/stp_cell.sv =====
// ----------------------------------------------------------------------------
// Spanning-tree port cell
// Holds one port's priority vector; takes its neighbour's on each shift.
// ----------------------------------------------------------------------------
module stp_cell
  import stp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  vec_t vec_i,
  output vec_t vec_o
);

  vec_t vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= '0;
    end else if (shift_i) begin
      vec_q <= vec_i;
    end
  end

  assign vec_o = vec_q;

endmodule

// ===== rtl/spanning_tree_bpdu_engine.sv =====
// ----------------------------------------------------------------------------
// Spanning-tree BPDU engine
// Port vectors live in a ring of cells rotating past one head processor.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one operation beat (init,
// received config message or hello tick). Output channel: out_valid_o /
// out_stall_i carry config records, last_o marking the final record of an
// operation. Config port: cfg_valid_i / cfg_ready_o with index and data,
// to be written only while the engine is idle; the engine does not enforce it.
// The ring rotates one port per cycle during a pass, unless the emit pass
// holds on a stalled record. Init takes one pass. A message takes a match
// pass, then ends, gives a single answer, or takes a select pass, a root
// step, an update pass and an emit pass. A hello tick, while hello is
// active, takes an update pass and an emit pass.
// One operation is handled at a time; in_stall_o is high while busy.
// A stalled record stays in the output register and the emit pass holds
// until it is taken. Reset clears all port vectors and the bridge state and
// sets hello active; registers return to their reset values.
// ----------------------------------------------------------------------------
module spanning_tree_bpdu_engine
  import stp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [2:0]  rx_port_i,
  input  logic [63:0] rx_root_id_i,
  input  logic [31:0] rx_root_cost_i,
  input  logic [63:0] rx_bridge_id_i,
  input  logic [15:0] rx_port_ident_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  tx_port_o,
  output logic [63:0] tx_root_id_o,
  output logic [31:0] tx_root_cost_o,
  output logic [63:0] tx_bridge_id_o,
  output logic [15:0] tx_port_ident_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

`include "spanning_tree_bpdu_engine_defines.svh"

  logic [63:0] own_q;
  logic [3:0]  ports_q;
  logic [7:0]  prio_q;
  logic [15:0] link_q;

  state_e state_q, state_d;
  logic [IDX_W-1:0] rot_q;
  logic rotate, hold, pass_end;

  vec_t cell_vec [MAX_PORTS];
  vec_t head, head_new;

  logic [2:0]  rx_port_q;
  vec_t        rx_q;
  logic        upd_q, was_root_q, better_q, desig_p_q;
  vec_t        best_q;
  logic [IDX_W-1:0] best_idx_q;
  logic        found_q;
  logic [63:0] bridge_root_q;
  logic [31:0] root_cost_q;
  logic        rpv_q;
  logic [2:0]  rpi_q;
  logic        hello_q;
  logic [CNT_W-1:0] cnt_q, cnt_next;
  logic [3:0]  total_q, sent_q;

  logic        out_valid_q;
  logic [2:0]  tx_port_q;
  logic [63:0] tx_root_q;
  logic [31:0] tx_cost_q;
  logic [15:0] tx_ident_q;
  logic        last_q;

  logic [CNT_W-1:0] n_act;
  logic act, at_p, p_act, desig, promote, desig2, cmp_rx, better_now, desig_p_now;
  logic may_send, out_busy, emit_now, load_out, accept;
  logic [15:0] head_ident;
  vec_t own_vec;

  // ports
  genvar g;
  generate
    for (g = 0; g < MAX_PORTS; g++) begin : g_cell
      vec_t nb;
      if (g == MAX_PORTS - 1) begin : g_tail
        assign nb = head_new;
      end else begin : g_mid
        assign nb = cell_vec[g + 1];
      end
      stp_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(rotate),
        .vec_i  (nb),
        .vec_o  (cell_vec[g])
      );
    end
  endgenerate

  assign head       = cell_vec[0];
  assign n_act      = (CNT_W'(ports_q) > CNT_W'(MAX_PORTS)) ? CNT_W'(MAX_PORTS)
                                                            : CNT_W'(ports_q);
  assign act        = CNT_W'(rot_q) < n_act;
  assign p_act      = CNT_W'(rx_port_q) < n_act;
  assign at_p       = CNT_W'(rot_q) == CNT_W'(rx_port_q);
  assign head_ident = ident_of(prio_q, 8'(rot_q));
  assign desig      = (head.bridge == own_q) && (head.ident == head_ident);
  assign cmp_rx     = head < rx_q;
  assign may_send   = (bridge_root_q == own_q) || rpv_q;
  assign own_vec    = '{root: bridge_root_q, cost: root_cost_q, bridge: own_q,
                        ident: head_ident};
  assign promote    = upd_q && found_q && act && !desig && !(head < own_vec);
  assign desig2     = desig || promote;
  assign cnt_next   = cnt_q + CNT_W'(act && desig2);
  assign pass_end   = rot_q == IDX_W'(MAX_PORTS - 1);
  assign better_now = at_p ? cmp_rx : better_q;
  assign desig_p_now = at_p ? desig : desig_p_q;
  assign out_busy   = out_valid_q && out_stall_i;
  assign emit_now   = act && desig && (sent_q < total_q);
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_INIT:  state_d = ST_INIT;
            OP_MSG:   state_d = ST_MATCH;
            OP_HELLO: state_d = hello_q ? ST_UPDATE : ST_IDLE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_INIT:   if (pass_end) state_d = ST_IDLE;
      ST_MATCH: begin
        if (pass_end) begin
          if (!p_act) state_d = ST_IDLE;
          else if (better_now) state_d = (desig_p_now && may_send) ? ST_ANSWER : ST_IDLE;
          else state_d = ST_SELECT;
        end
      end
      ST_ANSWER: if (!out_busy) state_d = ST_IDLE;
      ST_SELECT: if (pass_end) state_d = ST_ROOT;
      ST_ROOT:   state_d = ST_UPDATE;
      ST_UPDATE: if (pass_end) state_d = ST_EMIT;
      ST_EMIT:   if (pass_end && !hold) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ring control and head rewrite
  always_comb begin
    rotate   = 1'b0;
    hold     = 1'b0;
    load_out = 1'b0;
    head_new = head;
    case (state_q)
      ST_INIT: begin
        rotate   = 1'b1;
        head_new = '{root: own_q, cost: 32'd0, bridge: own_q, ident: head_ident};
      end
      ST_MATCH: begin
        rotate = 1'b1;
        if (at_p && p_act && !cmp_rx) head_new = rx_q;
      end
      ST_SELECT: rotate = 1'b1;
      ST_UPDATE: begin
        rotate = 1'b1;
        if (promote) begin
          head_new.bridge = own_q;
          head_new.ident  = head_ident;
        end
        if (upd_q && act && desig2) begin
          head_new.root = bridge_root_q;
          head_new.cost = root_cost_q;
        end
      end
      ST_ANSWER: load_out = !out_busy;
      ST_EMIT: begin
        hold     = emit_now && out_busy;
        rotate   = !hold;
        load_out = emit_now && !out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q   <= '0;
      ports_q <= 4'd8;
      prio_q  <= 8'd128;
      link_q  <= 16'd1;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_OWN_ID:   own_q   <= cfg_data_i;
        REG_PORTS:    ports_q <= cfg_data_i[3:0];
        REG_PRIORITY: prio_q  <= cfg_data_i[7:0];
        REG_COST:     link_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      rot_q         <= '0;
      bridge_root_q <= '0;
      root_cost_q   <= '0;
      rpv_q         <= 1'b0;
      rpi_q         <= '0;
      hello_q       <= 1'b1;
      out_valid_q   <= 1'b0;
      upd_q         <= 1'b0;
      found_q       <= 1'b0;
      better_q      <= 1'b0;
      desig_p_q     <= 1'b0;
      was_root_q    <= 1'b0;
      best_q        <= '0;
      best_idx_q    <= '0;
      cnt_q         <= '0;
      total_q       <= '0;
      sent_q        <= '0;
    end else begin
      state_q <= state_d;
      if (rotate) rot_q <= pass_end ? '0 : rot_q + IDX_W'(1);

      if (accept) begin
        upd_q      <= op_e'(operation_i) == OP_MSG;
        was_root_q <= bridge_root_q == own_q;
        found_q    <= 1'b0;
        cnt_q      <= '0;
        sent_q     <= '0;
        better_q   <= 1'b0;
      end

      case (state_q)
        ST_INIT: begin
          bridge_root_q <= own_q;
          root_cost_q   <= '0;
          rpv_q         <= 1'b0;
          rpi_q         <= '0;
          hello_q       <= 1'b1;
        end
        ST_MATCH: begin
          if (at_p) begin
            better_q  <= cmp_rx;
            desig_p_q <= desig;
          end
        end
        ST_SELECT: begin
          if (act && !desig && (!found_q || head < best_q)) begin
            found_q    <= 1'b1;
            best_q     <= head;
            best_idx_q <= rot_q;
          end
        end
        ST_ROOT: begin
          if (found_q) begin
            rpv_q         <= 1'b1;
            rpi_q         <= 3'(best_idx_q);
            bridge_root_q <= best_q.root;
            root_cost_q   <= best_q.cost + 32'(link_q);
            if (was_root_q && best_q.root != own_q) hello_q <= 1'b0;
          end else begin
            rpv_q         <= 1'b0;
            rpi_q         <= '0;
            bridge_root_q <= own_q;
            root_cost_q   <= '0;
          end
        end
        ST_UPDATE: begin
          cnt_q <= cnt_next;
          if (pass_end) begin
            if (!may_send) total_q <= '0;
            else if (cnt_next >= CNT_W'(OUT_LIMIT)) total_q <= 4'(OUT_LIMIT);
            else total_q <= 4'(cnt_next);
          end
        end
        ST_EMIT: if (load_out) sent_q <= sent_q + 4'd1;
        default: ;
      endcase

      if (load_out) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      tx_root_q <= bridge_root_q;
      tx_cost_q <= root_cost_q;
      if (state_q == ST_ANSWER) begin
        tx_port_q  <= rx_port_q;
        tx_ident_q <= ident_of(prio_q, 8'(rx_port_q));
        last_q     <= 1'b1;
      end else begin
        tx_port_q  <= 3'(rot_q);
        tx_ident_q <= head_ident;
        last_q     <= (sent_q + 4'd1) == total_q;
      end
    end
    if (accept) begin
      rx_port_q <= rx_port_i;
      rx_q      <= '{root: rx_root_id_i, cost: rx_root_cost_i, bridge: rx_bridge_id_i,
                     ident: rx_port_ident_i};
    end
  end

  assign in_stall_o      = state_q != ST_IDLE;
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign tx_port_o       = tx_port_q;
  assign tx_root_id_o    = tx_root_q;
  assign tx_root_cost_o  = tx_cost_q;
  assign tx_bridge_id_o  = own_q;
  assign tx_port_ident_o = tx_ident_q;
  assign last_o          = last_q;

  `STP_ASSERT(a_ring_home, (state_q == ST_IDLE) |-> (rot_q == '0), "ring not home when idle")
  `STP_ASSERT(a_sent_bound, sent_q <= total_q, "more records than counted")
  `STP_ASSERT(a_load_src, $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT || $past(state_q) == ST_ANSWER), "record outside emit")
  `STP_NEVER(a_idle_rotate, (state_q == ST_IDLE) && rotate, "ring moved while idle")

endmodule
